/* sv/flha_pkg.sv */
`timescale 1ns / 1ps
package flha_pkg;

  localparam int POOL_UNITS = 4096;
  localparam int UNIT_SHIFT = 4;
  localparam int ADDR_W = 12;
  localparam int SIZE_W = 13;
  localparam int FREE_BOUND = 2 * POOL_UNITS + 2;
  localparam int ALLOC_BOUND = 4 * POOL_UNITS + 8;
  localparam int FCNT_W = 14;
  localparam int ACNT_W = 15;

  localparam logic [11:0] GROW_RESET = 12'd1024;
  localparam logic [12:0] LIMIT_RESET = 13'd4096;

  localparam logic [1:0] CFG_GROW = 2'd0;
  localparam logic [1:0] CFG_LIMIT = 2'd1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_OOM = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_AFIRST = 15'b000000000000010,
    S_AREAD  = 15'b000000000000100,
    S_ACHK   = 15'b000000000001000,
    S_ASPLIT = 15'b000000000010000,
    S_GOLD   = 15'b000000000100000,
    S_ILOOK  = 15'b000000001000000,
    S_IWALK  = 15'b000000010000000,
    S_IHDR   = 15'b000000100000000,
    S_IMRG   = 15'b000001000000000,
    S_INX    = 15'b000010000000000,
    S_IPRD   = 15'b000100000000000,
    S_IPRV   = 15'b001000000000000,
    S_GNEXT  = 15'b010000000000000,
    S_DONE   = 15'b100000000000000
  } state_t;

endpackage

/* sv/free_list_heap_allocator_unit.sv */
// An allocate walks the free list from the rover and takes the first block that fits,
// splitting it when it is larger; if no block fits, the pool grows and the new block is
// inserted into the list before the walk resumes. A free walks the list to its place and
// merges with its neighbours; a free outside the claimed region is rejected with ST_BAD.
// One request at a time: in_ready is high only when idle; both header memories share one
// registered read port. Synchronous reset clears the rover, claimed region and out_valid.
`timescale 1ns / 1ps
module free_list_heap_allocator_unit
  import flha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [15:0] request_bytes,
  input  logic [11:0] block_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [11:0] payload_address,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  logic [ADDR_W-1:0] link_mem [POOL_UNITS];
  logic [SIZE_W-1:0] size_mem [POOL_UNITS];

  state_t state;
  logic [11:0] grow_min;
  logic [12:0] pool_limit;
  logic [ADDR_W-1:0] rover, prev, p, hdr, ip, nx, lkh, q;
  logic [SIZE_W-1:0] unclaimed, n, want, szh, old_size;
  logic [ACNT_W-1:0] steps;
  logic [FCNT_W-1:0] icnt;
  logic in_grow, lk0_written, sz0_written;
  logic [1:0] res_status;
  logic [ADDR_W-1:0] res_payload;

  logic [ADDR_W-1:0] raddr, raddr_q, lk_raw, lk_d;
  logic [SIZE_W-1:0] sz_raw, sz_d;
  logic lk_we, sz_we;
  logic [ADDR_W-1:0] lk_wa, sz_wa, lk_wd;
  logic [SIZE_W-1:0] sz_wd;

  always_ff @(posedge clk) begin
    lk_raw <= link_mem[raddr];
    sz_raw <= size_mem[raddr];
    raddr_q <= raddr;
    if (lk_we) begin
      link_mem[lk_wa] <= lk_wd;
    end
    if (sz_we) begin
      size_mem[sz_wa] <= sz_wd;
    end
  end

  assign lk_d = (raddr_q == '0 && !lk0_written) ? '0 : lk_raw;
  assign sz_d = (raddr_q == '0 && !sz0_written) ? '0 : sz_raw;

  logic [16:0] nb_round;
  logic [SIZE_W-1:0] n_in;
  logic [12:0] lim;
  logic [13:0] split_idx, hdr_end, prv_end, grow_end;
  logic walk_found, grow_ok, alloc_last;
  logic [FCNT_W-1:0] icnt_inc;

  assign nb_round = (request_bytes == 16'd0) ? 17'd16 : ({1'b0, request_bytes} + 17'd15);
  assign n_in = SIZE_W'(nb_round >> UNIT_SHIFT) + SIZE_W'(1);
  assign lim = (pool_limit < 13'(POOL_UNITS)) ? pool_limit : 13'(POOL_UNITS);
  assign want = (n < {1'b0, grow_min}) ? {1'b0, grow_min} : n;
  assign grow_ok = (unclaimed < lim) && ((lim - unclaimed) >= want);
  assign grow_end = {1'b0, unclaimed} + {1'b0, want};
  assign split_idx = {2'b00, p} + {1'b0, sz_d} - {1'b0, n};
  assign hdr_end = {2'b00, hdr} + {1'b0, sz_d};
  assign prv_end = {2'b00, ip} + {1'b0, sz_d};
  assign walk_found = (hdr > ip && hdr < lk_d) || (ip >= lk_d && (hdr > ip || hdr < lk_d));
  assign icnt_inc = icnt + FCNT_W'(1);
  assign alloc_last = (steps == ACNT_W'(ALLOC_BOUND));

  always_comb begin
    raddr = rover;
    lk_we = 1'b0;
    sz_we = 1'b0;
    lk_wa = p;
    sz_wa = p;
    lk_wd = '0;
    sz_wd = '0;
    case (state)
      S_IDLE: raddr = rover;
      S_AREAD: raddr = p;
      S_ACHK: begin
        if (sz_d == n) begin
          lk_we = 1'b1;
          lk_wa = prev;
          lk_wd = lk_d;
        end else if (sz_d > n) begin
          sz_we = 1'b1;
          sz_wa = p;
          sz_wd = sz_d - n;
        end else begin
          raddr = unclaimed[ADDR_W-1:0];
        end
      end
      S_ASPLIT: begin
        sz_we = 1'b1;
        sz_wa = q;
        sz_wd = n;
      end
      S_GOLD: begin
        sz_we = 1'b1;
        sz_wa = hdr;
        sz_wd = want;
      end
      S_ILOOK: raddr = ip;
      S_IWALK: begin
        if (!walk_found && icnt_inc > FCNT_W'(FREE_BOUND) && in_grow) begin
          sz_we = 1'b1;
          sz_wa = hdr;
          sz_wd = old_size;
        end
      end
      S_IHDR: raddr = hdr;
      S_IMRG: begin
        if (hdr_end == {2'b00, nx}) begin
          raddr = nx;
        end else begin
          lk_we = 1'b1;
          lk_wa = hdr;
          lk_wd = nx;
        end
      end
      S_INX: begin
        lk_we = 1'b1;
        lk_wa = hdr;
        lk_wd = lk_d;
        sz_we = 1'b1;
        sz_wa = hdr;
        sz_wd = szh + sz_d;
      end
      S_IPRD: raddr = ip;
      S_IPRV: begin
        lk_we = 1'b1;
        lk_wa = ip;
        if (prv_end == {2'b00, hdr}) begin
          lk_wd = lkh;
          sz_we = 1'b1;
          sz_wa = ip;
          sz_wd = sz_d + szh;
        end else begin
          lk_wd = hdr;
        end
      end
      S_GNEXT: raddr = p;
      default: raddr = rover;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      grow_min <= GROW_RESET;
      pool_limit <= LIMIT_RESET;
      rover <= '0;
      unclaimed <= SIZE_W'(1);
      lk0_written <= 1'b0;
      sz0_written <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_enable) begin
        if (cfg_index == CFG_GROW) begin
          grow_min <= cfg_data[11:0];
        end else if (cfg_index == CFG_LIMIT) begin
          pool_limit <= cfg_data;
        end
      end
      if (lk_we && lk_wa == '0) begin
        lk0_written <= 1'b1;
      end
      if (sz_we && sz_wa == '0) begin
        sz0_written <= 1'b1;
      end
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_payload <= '0;
            if (opcode == OP_FREE) begin
              if (block_address < 12'd2 || {1'b0, block_address - 12'd1} >= unclaimed) begin
                res_status <= ST_BAD;
                state <= S_DONE;
              end else begin
                hdr <= block_address - 12'd1;
                ip <= rover;
                icnt <= '0;
                in_grow <= 1'b0;
                state <= S_ILOOK;
              end
            end else begin
              n <= n_in;
              prev <= rover;
              steps <= '0;
              state <= S_AFIRST;
            end
          end
        end
        S_AFIRST: begin
          p <= lk_d;
          state <= S_AREAD;
        end
        S_AREAD: state <= S_ACHK;
        S_ACHK: begin
          if (sz_d >= n) begin
            rover <= prev;
            res_status <= ST_OK;
            if (sz_d == n) begin
              res_payload <= p + 12'd1;
              state <= S_DONE;
            end else begin
              q <= split_idx[ADDR_W-1:0];
              res_payload <= split_idx[ADDR_W-1:0] + 12'd1;
              state <= (split_idx < 14'(POOL_UNITS)) ? S_ASPLIT : S_DONE;
            end
          end else if (p == rover) begin
            if (!grow_ok) begin
              res_status <= ST_OOM;
              state <= S_DONE;
            end else begin
              hdr <= unclaimed[ADDR_W-1:0];
              state <= S_GOLD;
            end
          end else begin
            prev <= p;
            p <= lk_d;
            steps <= steps + ACNT_W'(1);
            if (alloc_last) begin
              res_status <= ST_OOM;
              state <= S_DONE;
            end else begin
              state <= S_AREAD;
            end
          end
        end
        S_ASPLIT: state <= S_DONE;
        S_GOLD: begin
          old_size <= sz_d;
          ip <= rover;
          icnt <= '0;
          in_grow <= 1'b1;
          state <= S_ILOOK;
        end
        S_ILOOK: state <= S_IWALK;
        S_IWALK: begin
          if (walk_found) begin
            nx <= lk_d;
            state <= S_IHDR;
          end else if (icnt_inc > FCNT_W'(FREE_BOUND)) begin
            res_status <= in_grow ? ST_OOM : ST_BAD;
            state <= S_DONE;
          end else begin
            ip <= lk_d;
            icnt <= icnt_inc;
            state <= S_ILOOK;
          end
        end
        S_IHDR: state <= S_IMRG;
        S_IMRG: begin
          szh <= sz_d;
          if (hdr_end == {2'b00, nx}) begin
            state <= S_INX;
          end else begin
            lkh <= nx;
            state <= S_IPRD;
          end
        end
        S_INX: begin
          szh <= szh + sz_d;
          lkh <= lk_d;
          state <= S_IPRD;
        end
        S_IPRD: state <= S_IPRV;
        S_IPRV: begin
          rover <= ip;
          if (!in_grow) begin
            res_status <= ST_OK;
            state <= S_DONE;
          end else begin
            unclaimed <= grow_end[SIZE_W-1:0];
            p <= ip;
            prev <= ip;
            steps <= steps + ACNT_W'(1);
            if (alloc_last) begin
              res_status <= ST_OOM;
              state <= S_DONE;
            end else begin
              state <= S_GNEXT;
            end
          end
        end
        S_GNEXT: state <= S_AFIRST;
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= res_status;
            payload_address <= (res_status == ST_OK) ? res_payload : '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
